>>> rtl/fhd_pkg.sv
// Shared types and constants for the fixed-header frame deframer.
// Used by fhd_parser and fixed_header_frame_deframer; no dependencies.
`default_nettype none

package fhd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 65536;
    localparam int unsigned ID_BYTES_DEF    = 32;

    localparam int unsigned CNT_W   = 17;
    localparam int unsigned VALUE_W = 17;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned LIMIT_W = 17;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;
    localparam logic [VALUE_W-1:0] VALUE_SAT   = 17'h1FFFF;

    localparam logic [7:0] HDR_BYTE0 = 8'hFF;
    localparam logic [7:0] HDR_BYTE1 = 8'hFE;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_SRC  = 3'd2,
        PH_DST  = 3'd3,
        PH_LEN  = 3'd4,
        PH_DATA = 3'd5,
        PH_TAIL = 3'd6
    } phase_t;

    localparam logic [2:0] SEC_TYPE = 3'd0;
    localparam logic [2:0] SEC_SRC  = 3'd1;
    localparam logic [2:0] SEC_DST  = 3'd2;
    localparam logic [2:0] SEC_LEN  = 3'd3;
    localparam logic [2:0] SEC_DATA = 3'd4;
    localparam logic [2:0] SEC_END  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TAIL = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    typedef struct packed {
        logic [2:0]         section;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic [1:0]         status;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/fhd_parser.sv
// Frame parser: phase state machine, counters and gather register.
// Consumes one byte per step and forms at most one result. Uses fhd_pkg.
`default_nettype none

module fhd_parser #(
    parameter int unsigned MAX_PAYLOAD = fhd_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned ID_BYTES    = fhd_pkg::ID_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [7:0]                   step_byte,
    input  wire logic [fhd_pkg::LIMIT_W-1:0]  payload_limit,
    output logic                              res_valid,
    output fhd_pkg::result_t                  res
);

    localparam logic [fhd_pkg::CNT_W-1:0] ID_COUNT  = fhd_pkg::CNT_W'(ID_BYTES);
    localparam logic [31:0]               MAX_LIMIT = 32'(MAX_PAYLOAD);

    fhd_pkg::phase_t             phase_reg, phase_next;
    logic                        seen_ff_reg, seen_ff_next;
    logic [fhd_pkg::CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [31:0]                 gather_word_reg, gather_word_next;
    logic [fhd_pkg::CNT_W-1:0]   frame_length_reg, frame_length_next;
    logic                        tail_bad_reg, tail_bad_next;

    logic [fhd_pkg::CNT_W-1:0]   cnt_inc;
    logic [31:0]                 gathered;
    logic [31:0]                 eff_limit;
    logic                        len_bad;
    logic                        tail_bad_now;

    assign cnt_inc = byte_count_reg + 1'b1;

    // Little-endian byte insert; type uses lanes 0-1, length lanes 0-3
    always_comb
    begin
        gathered = gather_word_reg;
        case (byte_count_reg[1:0])
            2'd0: gathered[7:0]   = gather_word_reg[7:0]   | step_byte;
            2'd1: gathered[15:8]  = gather_word_reg[15:8]  | step_byte;
            2'd2: gathered[23:16] = gather_word_reg[23:16] | step_byte;
            default: gathered[31:24] = gather_word_reg[31:24] | step_byte;
        endcase
    end

    assign eff_limit = ({15'd0, payload_limit} > MAX_LIMIT) ? MAX_LIMIT
                                                            : {15'd0, payload_limit};
    assign len_bad      = gathered[31] || (gathered > eff_limit);
    assign tail_bad_now = tail_bad_reg || (step_byte != fhd_pkg::TAIL_BYTE);

    always_comb
    begin
        phase_next        = phase_reg;
        seen_ff_next      = seen_ff_reg;
        byte_count_next   = byte_count_reg;
        gather_word_next  = gather_word_reg;
        frame_length_next = frame_length_reg;
        tail_bad_next     = tail_bad_reg;
        res_valid         = 1'b0;
        res               = '0;

        unique case (phase_reg)
            fhd_pkg::PH_HUNT:
            begin
                if (seen_ff_reg && step_byte == fhd_pkg::HDR_BYTE1)
                begin
                    seen_ff_next     = 1'b0;
                    phase_next       = fhd_pkg::PH_TYPE;
                    byte_count_next  = '0;
                    gather_word_next = '0;
                end
                else
                begin
                    seen_ff_next = (step_byte == fhd_pkg::HDR_BYTE0);
                end
            end
            fhd_pkg::PH_TYPE:
            begin
                gather_word_next = gathered;
                byte_count_next  = cnt_inc;
                if (byte_count_reg[0])
                begin
                    res_valid       = 1'b1;
                    res.section     = fhd_pkg::SEC_TYPE;
                    res.value       = {1'b0, gathered[15:0]};
                    phase_next      = fhd_pkg::PH_SRC;
                    byte_count_next = '0;
                end
            end
            fhd_pkg::PH_SRC, fhd_pkg::PH_DST:
            begin
                res_valid       = 1'b1;
                res.section     = (phase_reg == fhd_pkg::PH_SRC) ? fhd_pkg::SEC_SRC
                                                                 : fhd_pkg::SEC_DST;
                res.value       = {9'd0, step_byte};
                res.position    = byte_count_reg[fhd_pkg::POS_W-1:0];
                byte_count_next = cnt_inc;
                if (cnt_inc >= ID_COUNT)
                begin
                    byte_count_next  = '0;
                    gather_word_next = '0;
                    phase_next       = (phase_reg == fhd_pkg::PH_SRC) ? fhd_pkg::PH_DST
                                                                      : fhd_pkg::PH_LEN;
                end
            end
            fhd_pkg::PH_LEN:
            begin
                gather_word_next = gathered;
                byte_count_next  = cnt_inc;
                if (byte_count_reg[1:0] == 2'd3)
                begin
                    res_valid   = 1'b1;
                    res.section = fhd_pkg::SEC_LEN;
                    if (len_bad)
                    begin
                        res.value        = (gathered > 32'(fhd_pkg::VALUE_SAT))
                                           ? fhd_pkg::VALUE_SAT
                                           : gathered[fhd_pkg::VALUE_W-1:0];
                        res.status       = fhd_pkg::ST_BAD_LEN;
                        res.last         = 1'b1;
                        phase_next       = fhd_pkg::PH_HUNT;
                        seen_ff_next     = 1'b0;
                        byte_count_next  = '0;
                        gather_word_next = '0;
                        tail_bad_next    = 1'b0;
                    end
                    else
                    begin
                        // good length is at most the 17-bit limit
                        frame_length_next = gathered[fhd_pkg::CNT_W-1:0];
                        res.value         = gathered[fhd_pkg::VALUE_W-1:0];
                        byte_count_next   = '0;
                        tail_bad_next     = 1'b0;
                        phase_next        = (gathered == 32'd0) ? fhd_pkg::PH_TAIL
                                                                : fhd_pkg::PH_DATA;
                    end
                end
            end
            fhd_pkg::PH_DATA:
            begin
                res_valid       = 1'b1;
                res.section     = fhd_pkg::SEC_DATA;
                res.value       = {9'd0, step_byte};
                res.position    = byte_count_reg[fhd_pkg::POS_W-1:0];
                byte_count_next = cnt_inc;
                if (cnt_inc >= frame_length_reg)
                begin
                    byte_count_next = '0;
                    tail_bad_next   = 1'b0;
                    phase_next      = fhd_pkg::PH_TAIL;
                end
            end
            fhd_pkg::PH_TAIL:
            begin
                tail_bad_next = tail_bad_now;
                if (byte_count_reg == '0)
                begin
                    byte_count_next = {{(fhd_pkg::CNT_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.section      = fhd_pkg::SEC_END;
                    res.status       = tail_bad_now ? fhd_pkg::ST_BAD_TAIL : fhd_pkg::ST_OK;
                    res.last         = 1'b1;
                    phase_next       = fhd_pkg::PH_HUNT;
                    seen_ff_next     = 1'b0;
                    byte_count_next  = '0;
                    gather_word_next = '0;
                    tail_bad_next    = 1'b0;
                end
            end
            default:
            begin
                phase_next       = fhd_pkg::PH_HUNT;
                seen_ff_next     = 1'b0;
                byte_count_next  = '0;
                gather_word_next = '0;
                tail_bad_next    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= fhd_pkg::PH_HUNT;
            seen_ff_reg      <= 1'b0;
            byte_count_reg   <= '0;
            gather_word_reg  <= '0;
            frame_length_reg <= '0;
            tail_bad_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            seen_ff_reg      <= seen_ff_next;
            byte_count_reg   <= byte_count_next;
            gather_word_reg  <= gather_word_next;
            frame_length_reg <= frame_length_next;
            tail_bad_reg     <= tail_bad_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fixed_header_frame_deframer.sv
// Top level of the fixed-header frame deframer: input register, limit register,
// output register around fhd_parser. Uses fhd_pkg and fhd_parser.
//
//   channel   signals                                   dir   request
//   in        in_valid in_stall in_byte                 in    one received byte
//   out       out_valid out_stall section value         out   one result
//             position status last
//   cfg       cfg_wen cfg_wdata                         in    payload_limit write
//
// One byte per cycle sustained while the output is not stalled; a taken byte is
// held in the input register, then the parser feeds its result into the
// output register. Bytes that make no result (header, gathered bytes, first
// tail byte) leave the output register untouched. Reset clears the frame search
// and sets the limit to 65536. A stalled output holds the pipe; input stall
// follows at once.
`default_nettype none

module fixed_header_frame_deframer #(
    parameter int unsigned MAX_PAYLOAD = fhd_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned ID_BYTES    = fhd_pkg::ID_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   in_byte,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [2:0]                        section,
    output logic [fhd_pkg::VALUE_W-1:0]       value,
    output logic [fhd_pkg::POS_W-1:0]         position,
    output logic [1:0]                        status,
    output logic                              last,
    input  wire logic                         cfg_wen,
    input  wire logic [fhd_pkg::LIMIT_W-1:0]  cfg_wdata
);

    logic                          in_valid_reg, in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg, out_valid_next;
    fhd_pkg::result_t              out_reg;
    logic [fhd_pkg::LIMIT_W-1:0]   limit_reg;

    logic                          can_load;
    logic                          advance;
    logic                          in_take;
    logic                          res_valid;
    fhd_pkg::result_t              res;

    assign can_load = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && can_load;
    assign in_stall = in_valid_reg && !can_load;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? res_valid : (out_valid_reg && out_stall);

    fhd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ID_BYTES    (ID_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .step_byte     (in_byte_reg),
        .payload_limit (limit_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= fhd_pkg::LIMIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign section   = out_reg.section;
    assign value     = out_reg.value;
    assign position  = out_reg.position;
    assign status    = out_reg.status;
    assign last      = out_reg.last;

endmodule

`default_nettype wire
